[sv/wdce_pkg.sv]
// Shared types, constants and helpers for the WOTS digit and checksum encoder.
package wdce_pkg;

	// Upper bound on checksum digits per encoding
	localparam logic [3:0] CKS_DIGITS_MAX = 4'd10;

	// Register indexes on the configuration port
	localparam logic CFG_DIGIT_BITS = 1'b0;
	localparam logic CFG_CKS_DIGITS = 1'b1;

	// Back-end phase: message digits or checksum digits
	typedef enum logic {
		PH_MSG,
		PH_CKS
	} phase_t;

	// One classified digest byte, as queued between front and back
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       last;
		logic [1:0] code;      // digit width code
		logic [3:0] ncs;       // checksum digits after clipping
		logic [2:0] last_idx;  // digits per byte minus one
		logic [3:0] cks_shift; // left shift applied to the checksum
		logic [6:0] p0;        // bit position of the first checksum digit
	} entry_t;

	// Digit width in bits for a width code
	function automatic logic [3:0] digit_bits(input logic [1:0] code);
		logic [3:0] r;
		case (code)
			2'd0: r = 4'd1;
			2'd1: r = 4'd2;
			2'd2: r = 4'd4;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

	// Digit mask w-1 for a width code
	function automatic logic [7:0] digit_mask(input logic [1:0] code);
		logic [7:0] r;
		case (code)
			2'd0: r = 8'h01;
			2'd1: r = 8'h03;
			2'd2: r = 8'h0f;
			default: r = 8'hff;
		endcase
		return r;
	endfunction

endpackage

[sv/wdce_front.sv]
// Front end: configuration registers, input beat acceptance and classification.
module wdce_front import wdce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] msg_byte
	input  logic       s_tlast,   // last_byte
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	logic [1:0] code_q;
	logic [3:0] cks_digits_q;
	logic [3:0] ncs;
	logic [6:0] tbits;
	logic [7:0] nb_up;
	logic [6:0] nbits;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q       <= 2'd2;
			cks_digits_q <= 4'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIGIT_BITS: code_q <= cfg_data[1:0];
				CFG_CKS_DIGITS: cks_digits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Accept a beat whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Classify the byte under the configuration in force now
	always_comb begin
		ncs   = (cks_digits_q > CKS_DIGITS_MAX) ? CKS_DIGITS_MAX : cks_digits_q;
		tbits = 7'({3'b000, ncs} << code_q);
		nb_up = {1'b0, tbits} + 8'd7;
		nbits = {nb_up[6:3], 3'b000};

		q_entry.msg_byte  = s_tdata;
		q_entry.last      = s_tlast;
		q_entry.code      = code_q;
		q_entry.ncs       = ncs;
		q_entry.last_idx  = 3'((4'd8 >> code_q) - 4'd1);
		q_entry.cks_shift = 4'd8 - {1'b0, tbits[2:0]};
		q_entry.p0        = nbits - {3'b000, digit_bits(code_q)};
	end

endmodule

[sv/wdce_fifo.sv]
// Short queue of classified bytes between front and back ends.
module wdce_fifo import wdce_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output entry_t rd_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t          mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == FULL_CNT);
	assign valid    = (count_q != '0);
	assign rd_entry = mem[rd_ptr_q];

	// Store entries at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/wdce_back.sv]
// Back end: digit sequencer, checksum accumulator and output register.
module wdce_back import wdce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  entry_t     q_entry,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] digit
	output logic       m_tuser,   // is_checksum
	output logic       m_tlast    // last_digit
);

	phase_t      phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [3:0]  cidx_q, cidx_d;
	logic [6:0]  p_q, p_d;
	logic [15:0] sum_q, sum_d;

	logic        m_tvalid_q;
	logic [7:0]  digit_q;
	logic        cks_q;
	logic        last_q;

	logic        go;
	logic [3:0]  bw;
	logic [7:0]  mask;
	logic [3:0]  pos;
	logic [3:0]  sh;
	logic [7:0]  d_msg;
	logic [23:0] v;
	logic [7:0]  d_cks;
	logic [16:0] sum_add;
	logic [7:0]  out_digit;
	logic        out_cks;
	logic        out_last;
	logic        msg_end;
	logic        cks_end;

	// Produce a digit when a byte is queued and the output slot frees
	assign go = q_valid && (!m_tvalid_q || m_tready);

	// Digit datapath for both phases
	always_comb begin
		bw      = digit_bits(q_entry.code);
		mask    = digit_mask(q_entry.code);
		pos     = 4'(({1'b0, idx_q} + 4'd1) << q_entry.code);
		sh      = 4'd8 - pos;
		d_msg   = (q_entry.msg_byte >> sh) & mask;
		v       = 24'(sum_q) << q_entry.cks_shift;
		d_cks   = (p_q < 7'd24) ? (8'(v >> p_q) & mask) : 8'h00;
		sum_add = {1'b0, sum_q} + {9'd0, mask - d_msg};
		msg_end = (idx_q == q_entry.last_idx);
		cks_end = (cidx_q == q_entry.ncs - 4'd1);
	end

	// Select the result fields
	always_comb begin
		case (phase_q)
			PH_CKS: begin
				out_digit = d_cks;
				out_cks   = 1'b1;
				out_last  = cks_end;
			end
			default: begin
				out_digit = d_msg;
				out_cks   = 1'b0;
				out_last  = q_entry.last && (q_entry.ncs == 4'd0) && msg_end;
			end
		endcase
	end

	// Next state of the sequencer and accumulator
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		cidx_d  = cidx_q;
		p_d     = p_q;
		sum_d   = sum_q;
		q_pop   = 1'b0;
		if (go) begin
			case (phase_q)
				PH_CKS: begin
					p_d    = p_q - {3'b000, bw};
					cidx_d = cidx_q + 4'd1;
					if (cks_end) begin
						q_pop   = 1'b1;
						sum_d   = '0;
						cidx_d  = '0;
						phase_d = PH_MSG;
					end
				end
				default: begin
					sum_d = sum_add[16] ? 16'hffff : sum_add[15:0];
					if (msg_end) begin
						idx_d = '0;
						if (q_entry.last && (q_entry.ncs != 4'd0)) begin
							phase_d = PH_CKS;
							cidx_d  = '0;
							p_d     = q_entry.p0;
						end else begin
							q_pop = 1'b1;
							if (q_entry.last) begin
								sum_d = '0;
							end
						end
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			endcase
		end
	end

	// Update sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MSG;
			idx_q   <= '0;
			cidx_q  <= '0;
			p_q     <= '0;
			sum_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			cidx_q  <= cidx_d;
			p_q     <= p_d;
			sum_q   <= sum_d;
		end
	end

	// Hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			digit_q <= out_digit;
			cks_q   <= out_cks;
			last_q  <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = digit_q;
	assign m_tuser  = cks_q;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_cks_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CKS |-> q_valid)
		else $error("checksum phase without a queued byte");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && phase_q == PH_MSG |-> idx_q <= q_entry.last_idx)
		else $error("digit index past end of byte");

	a_clear_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		go && out_last |=> sum_q == 16'h0000)
		else $error("checksum not cleared after final digit");

	a_cks_flag: assert property (@(posedge clk) disable iff (!arst_n)
		go && phase_q == PH_CKS |=> m_tvalid_q && cks_q)
		else $error("checksum digit not flagged");
`endif

endmodule

[sv/wots_digit_checksum_encoder_unit.sv]
// Top level of the WOTS base-w digit and checksum encoder.
// An accepted digest byte is written into the queue; its digits leave through the output register.
// Throughput: one digit per cycle from the back-end sequencer while bytes are queued and
// m_tready is high; a byte yields 8 >> digit_bits_code digits (2 at w=16), plus
// min(checksum_digits, 10) checksum digits on the last byte.
// The input side keeps accepting into a QUEUE_DEPTH-entry queue while digits drain.
// Reset: asynchronous, clears the queue, the checksum and the output valid flag and
// loads digit_bits_code = 2 and checksum_digits = 3.
module wots_digit_checksum_encoder_unit import wdce_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] msg_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] digit
	output logic       m_tuser,   // is_checksum
	output logic       m_tlast    // last_digit
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_valid;
	entry_t q_wr_entry;
	entry_t q_rd_entry;

	wdce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr_entry)
	);

	wdce_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.rd_entry (q_rd_entry)
	);

	wdce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_rd_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[sim/tb_wots_digit_checksum_encoder_unit.sv]
// Self-checking testbench for the WOTS base-w digit and checksum encoder.
`timescale 1ns / 100ps

module tb_wots_digit_checksum_encoder_unit;
	import wdce_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 205;

	// One output beat: digit with its two flags
	typedef struct packed {
		logic [7:0] digit;
		logic       is_cks;
		logic       last;
	} digit_beat_t;

	// One input beat: digest byte and its end-of-digest mark
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       last;
	} byte_beat_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_DIGIT_BITS;
	logic [3:0] cfg_data = 4'd0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;   // [7:0] msg_byte
	logic       s_tlast = 1'b0;   // last_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] digit
	logic       m_tuser;          // is_checksum
	logic       m_tlast;          // last_digit

	byte_beat_t  bytes_to_send[$];
	digit_beat_t digits_due[$];
	digit_beat_t due;
	byte_beat_t  next_byte;
	int          bytes_queued = 0;
	int          bytes_taken = 0;
	int          mismatches = 0;
	int          cycles = 0;
	bit          steady = 1'b0;

	// Mirror of the configuration and the running checksum
	logic [1:0]  width_code = 2'd2;
	logic [3:0]  cks_count = 4'd3;
	int unsigned cks_sum = 0;

	wots_digit_checksum_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Split one byte into digits, fold them into the checksum, and on the
	// final byte append the checksum digits
	function automatic void encode_byte(input logic [7:0] data, input logic fin);
		int unsigned nb, mask, per, ncs, d, tbits, shft, nbits, p;
		longint unsigned v;
		digit_beat_t beat;
		nb = 1 << width_code;
		mask = (1 << nb) - 1;
		per = 8 / nb;
		ncs = (cks_count > CKS_DIGITS_MAX) ? CKS_DIGITS_MAX : cks_count;
		for (int i = 0; i < per; i++) begin
			d = (data >> (8 - (i + 1) * nb)) & mask;
			cks_sum = cks_sum + (mask - d);
			if (cks_sum > 16'hffff)
				cks_sum = 16'hffff;
			beat.digit = d[7:0];
			beat.is_cks = 1'b0;
			beat.last = fin && ncs == 0 && i + 1 == per;
			digits_due.push_back(beat);
		end
		if (fin) begin
			tbits = ncs * nb;
			shft = 8 - (tbits % 8);
			nbits = ((tbits + 7) / 8) * 8;
			v = longint'(cks_sum) << shft;
			for (int i = 0; i < ncs; i++) begin
				p = nbits - (i + 1) * nb;
				d = (p < 64) ? int'((v >> p) & mask) : 0;
				beat.digit = d[7:0];
				beat.is_cks = 1'b1;
				beat.last = (i + 1 == ncs);
				digits_due.push_back(beat);
			end
			cks_sum = 0;
		end
	endfunction

	// Input driver: predict on each accepted beat, then load the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (bytes_to_send.size() != 0 &&
						(steady || $urandom_range(0, 99) >= 28)) begin
					next_byte = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.msg_byte;
					s_tlast <= next_byte.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each digit beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (digits_due.size() == 0) begin
					$error("digit: none expected, got %0h (is_checksum %0b, last_digit %0b)",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					due = digits_due.pop_front();
					if (m_tdata !== due.digit) begin
						$error("digit: expected %0h, got %0h", due.digit, m_tdata);
						mismatches++;
					end
					if (m_tuser !== due.is_cks) begin
						$error("is_checksum: expected %0b, got %0b", due.is_cks, m_tuser);
						mismatches++;
					end
					if (m_tlast !== due.last) begin
						$error("last_digit: expected %0b, got %0b", due.last, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= steady || $urandom_range(0, 99) >= 28;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("wots_digit_checksum_encoder_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [3:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_DIGIT_BITS)
			width_code = val[1:0];
		else
			cks_count = val;
	endtask

	// Set width code (with junk in the unused upper bits) and checksum digits
	task automatic configure(input logic [1:0] code, input logic [3:0] ncs);
		write_reg(CFG_DIGIT_BITS, {2'($urandom_range(0, 3)), code});
		write_reg(CFG_CKS_DIGITS, ncs);
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic fin);
		byte_beat_t b;
		b.msg_byte = data;
		b.last = fin;
		bytes_to_send.push_back(b);
		bytes_queued++;
	endtask

	// Wait until every byte is taken and every digit has come out
	task automatic drain();
		do @(posedge clk); while (bytes_taken != bytes_queued || digits_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_message(input int len, input bit finish);
		for (int i = 0; i < len; i++)
			queue_byte(8'($urandom_range(0, 255)), finish && i == len - 1);
	endtask

	initial begin
		logic [3:0] ncs;
		int len;
		int sent;
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: w=16, three checksum digits
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'ha5, 1'b1);
		drain();

		// Binary digits, most checksum digits
		configure(2'd0, 4'd10);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h00, 1'b1);
		drain();

		// w=4 with a single checksum digit
		configure(2'd1, 4'd1);
		queue_byte(8'h00, 1'b1);
		drain();

		// No checksum digits: last flag lands on the final message digit
		configure(2'd3, 4'd0);
		queue_byte(8'hff, 1'b0);
		queue_byte(8'h80, 1'b1);
		drain();

		// Checksum digit count above the maximum gets clipped
		configure(2'd3, 4'd15);
		queue_byte(8'h00, 1'b1);
		drain();
		configure(2'd1, 4'd11);
		queue_byte(8'hc3, 1'b1);
		drain();

		// Byte-aligned checksum fields take a full 8-bit shift
		configure(2'd2, 4'd2);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		drain();
		configure(2'd0, 4'd8);
		queue_byte(8'h00, 1'b1);
		drain();

		// Width change in the middle of a digest
		configure(2'd2, 4'd3);
		queue_byte(8'h12, 1'b0);
		drain();
		configure(2'd0, 4'd5);
		queue_byte(8'h34, 1'b1);
		drain();

		// Random digests under random settings; some phases stop mid-digest
		sent = 0;
		phase = 0;
		while (sent < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: ncs = 4'd0;
				1: ncs = 4'($urandom_range(11, 15));
				2: ncs = 4'd10;
				3: ncs = 4'd1;
				default: ncs = 4'($urandom_range(1, 10));
			endcase
			configure(2'($urandom_range(0, 3)), ncs);
			steady = (phase == 3);
			for (int m = 0; m < $urandom_range(2, 5); m++) begin
				len = ($urandom_range(0, 7) == 0) ?
					$urandom_range(8, 20) : $urandom_range(1, 6);
				random_message(len, 1'b1);
				sent += len;
			end
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 3);
				random_message(len, 1'b0);
				sent += len;
			end
			drain();
			steady = 1'b0;
			phase++;
		end

		// Allow any stray digits to surface
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("wots_digit_checksum_encoder_unit: match");
		else
			$display("wots_digit_checksum_encoder_unit: mismatch");
		$finish;
	end

endmodule
